/* design/lpd_pkg.sv */
// Shared types and constants for the length-prefixed deframer.
// No dependencies; compiled first.
package lpd_pkg;

    // Low bits of the header length field that are kept (8 to 32)
    localparam int LENGTH_WIDTH = 32;

    // Header layout: four length bytes, then four type bytes
    localparam int HDR_BYTES   = 8;
    localparam int CNT_WIDTH   = 4;
    localparam int TYPE_WIDTH  = 32;
    localparam int BYTE_WIDTH  = 8;

    // Header position of the last type byte
    localparam logic [2:0] HDR_LAST_POS = 3'(HDR_BYTES - 1);

    typedef logic [LENGTH_WIDTH-1:0] len_t;
    typedef logic [TYPE_WIDTH-1:0]   type_word_t;
    typedef logic [BYTE_WIDTH-1:0]   byte_t;
    typedef logic [CNT_WIDTH-1:0]    hdr_cnt_t;

    // One result request, produced by the header tracker for the output stage
    typedef struct packed {
        logic       valid;
        byte_t      payload_byte;
        type_word_t frame_type;
        logic       has_data;
        logic       last;
    } lpd_result_t;

endpackage

/* design/lpd_in_if.sv */
// Input byte channel: valid/ready handshake carrying one stream byte.
// Depends on lpd_pkg.
interface lpd_in_if import lpd_pkg::*;;
    logic  valid;
    logic  ready;
    byte_t stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

/* design/lpd_out_if.sv */
// Result channel: valid/ready handshake carrying one tagged payload byte.
// Depends on lpd_pkg.
interface lpd_out_if import lpd_pkg::*;;
    logic       valid;
    logic       ready;
    byte_t      payload_byte;
    type_word_t frame_type;
    logic       has_data;
    logic       last;

    modport source (output valid, output payload_byte, output frame_type,
                    output has_data, output last, input ready);
    modport sink   (input valid, input payload_byte, input frame_type,
                    input has_data, input last, output ready);
endinterface

/* design/lpd_hdr_track.sv */
// Header tracker: assembles length and type, counts payload bytes and
// forms the result request for each payload byte and empty frame. Depends on lpd_pkg.
module lpd_hdr_track import lpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  byte_t       stream_byte,
    output lpd_result_t res
);

    hdr_cnt_t   cnt_reg,  cnt_next;
    len_t       len_reg,  len_next;
    type_word_t type_reg, type_next;
    len_t       left_reg, left_next;

    logic [2:0] pos;
    logic       in_payload;

    // Payload phase with nothing left restarts the header at byte zero
    assign in_payload = cnt_reg[3] && (left_reg != '0);
    assign pos        = cnt_reg[3] ? 3'd0 : cnt_reg[2:0];

    // Decode the byte against the current phase
    always_comb
    begin
        cnt_next  = cnt_reg;
        len_next  = len_reg;
        type_next = type_reg;
        left_next = left_reg;
        res       = '0;

        if (in_payload)
        begin
            // Payload phase: emit the byte, close the frame on the final one
            left_next        = left_reg - len_t'(1);
            res.valid        = 1'b1;
            res.payload_byte = stream_byte;
            res.frame_type   = type_reg;
            res.has_data     = 1'b1;
            res.last         = (left_reg == len_t'(1));
            if (res.last)
            begin
                cnt_next = '0;
            end
        end
        else
        begin
            // Header phase: write the byte into its lane
            if (!pos[2])
            begin
                for (int i = 0; i < LENGTH_WIDTH; i++)
                begin
                    if (pos[1:0] == 2'(i >> 3))
                    begin
                        len_next[i] = stream_byte[3'(i & 7)];
                    end
                end
            end
            else
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if (pos[1:0] == 2'(k))
                    begin
                        type_next[8*k +: 8] = stream_byte;
                    end
                end
            end
            cnt_next = hdr_cnt_t'(pos) + hdr_cnt_t'(1);

            // Header complete: start payload, or mark an empty frame
            if (pos == HDR_LAST_POS)
            begin
                if (len_reg == '0)
                begin
                    cnt_next       = '0;
                    left_next      = '0;
                    res.valid      = 1'b1;
                    res.frame_type = {stream_byte, type_reg[23:0]};
                    res.last       = 1'b1;
                end
                else
                begin
                    left_next = len_reg;
                end
            end
        end
    end

    // Advance state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            len_reg  <= '0;
            type_reg <= '0;
            left_reg <= '0;
        end
        else if (take)
        begin
            cnt_reg  <= cnt_next;
            len_reg  <= len_next;
            type_reg <= type_next;
            left_reg <= left_next;
        end
    end

endmodule

/* design/length_prefixed_deframer.sv */
// Length-prefixed deframer: the result of an accepted byte is loaded into the
// output register on the edge that accepts it. Throughput one byte per cycle; the input
// stalls only while a result is held and the sink is not ready.
// Reset (rst_n low, asynchronous) clears the header counter, length, type and
// remaining count to zero and empties the output register.
// Depends on lpd_pkg, lpd_in_if, lpd_out_if and lpd_hdr_track.
module length_prefixed_deframer import lpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lpd_in_if.sink     stream,
    lpd_out_if.source  result
);

    lpd_result_t res;
    lpd_result_t out_reg;
    logic        out_valid_reg, out_valid_next;
    logic        take;

    // Accept a byte whenever the output register is free or being drained
    assign stream.ready = !out_valid_reg || result.ready;
    assign take         = stream.valid && stream.ready;

    lpd_hdr_track u_hdr_track
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .stream_byte (stream.stream_byte),
        .res         (res)
    );

    // Hold the result request until the sink takes it
    always_comb
    begin
        if (take && res.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load payload only on a new result request
    always_ff @(posedge clk)
    begin
        if (take && res.valid)
        begin
            out_reg <= res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.payload_byte = out_reg.payload_byte;
    assign result.frame_type   = out_reg.frame_type;
    assign result.has_data     = out_reg.has_data;
    assign result.last         = out_reg.last;

endmodule

/* design/lpd_checker.sv */
// Port-level checks for the length-prefixed deframer, bound to the top level.
// Depends on lpd_pkg.
module lpd_checker import lpd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input byte_t      payload_byte,
    input type_word_t frame_type,
    input logic       has_data,
    input logic       last
);

    // A stalled result request stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped while stalled");

    // A stalled result request keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(payload_byte) && $stable(frame_type)
            && $stable(has_data) && $stable(last))
        else $error("result payload changed while stalled");

    // An empty-frame marker carries a zero byte and closes the frame
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_data |-> last && (payload_byte == '0))
        else $error("malformed empty-frame marker");

    // A new result only follows an accepted byte
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result appeared without an accepted byte");

    // The input is never stalled while the output register is empty
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (stream.valid),
    .in_ready     (stream.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .payload_byte (result.payload_byte),
    .frame_type   (result.frame_type),
    .has_data     (result.has_data),
    .last         (result.last)
);

/* verif/length_prefixed_deframer_test.sv */
// Self-checking testbench for the length-prefixed deframer: drives whole frames
// into the byte channel with random gaps and stalls, and predicts every result.
// Depends on lpd_pkg, lpd_in_if, lpd_out_if and length_prefixed_deframer.
module length_prefixed_deframer_test;
    import lpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          BYTE_TARGET = 1100;
    localparam int          IDLE_LIMIT  = 2000;
    localparam logic [31:0] LEN_MASK    = 32'((64'd1 << LENGTH_WIDTH) - 64'd1);

    typedef struct {
        byte_t      payload_byte;
        type_word_t frame_type;
        logic       has_data;
        logic       last;
    } tagged_byte_t;

    // Frame tracker: rebuilds headers, counts payload and holds expected results
    class frame_tracker;
        hdr_cnt_t     header_count;
        logic [31:0]  frame_length;
        type_word_t   type_word;
        logic [31:0]  bytes_left;
        tagged_byte_t expected_q[$];
        int           fail_count;

        function new();
            header_count = '0;
            frame_length = '0;
            type_word    = '0;
            bytes_left   = '0;
            fail_count   = 0;
        endfunction

        function void take_byte(byte_t b);
            tagged_byte_t r;
            logic [2:0]   pos;
            int           sh;
            // Payload phase: tag the byte, flag the end of the frame
            if (header_count >= HDR_BYTES && bytes_left != 0) begin
                bytes_left     = bytes_left - 1;
                r.payload_byte = b;
                r.frame_type   = type_word;
                r.has_data     = 1'b1;
                r.last         = (bytes_left == 0);
                expected_q     = {expected_q, r};
                if (bytes_left == 0)
                    header_count = '0;
                return;
            end
            // Payload phase with nothing left: restart the header
            if (header_count >= HDR_BYTES)
                header_count = '0;
            pos = header_count[2:0];
            sh  = int'(pos[1:0]) * 8;
            if (pos < 4)
                frame_length[sh +: 8] = b;
            else
                type_word[sh +: 8] = b;
            header_count = hdr_cnt_t'(pos) + 1'b1;
            if (header_count < HDR_BYTES)
                return;
            frame_length = frame_length & LEN_MASK;
            if (frame_length == 0) begin
                // Empty frame: emit the marker and go back to the header
                header_count   = '0;
                bytes_left     = '0;
                r.payload_byte = '0;
                r.frame_type   = type_word;
                r.has_data     = 1'b0;
                r.last         = 1'b1;
                expected_q     = {expected_q, r};
            end
            else begin
                bytes_left = frame_length;
            end
        endfunction

        function void check_result(byte_t pb, type_word_t ft, logic hd, logic ls);
            tagged_byte_t e;
            if (expected_q.size() == 0) begin
                $error("unexpected result: payload_byte %0h frame_type %0h has_data %0b last %0b",
                       pb, ft, hd, ls);
                fail_count++;
                return;
            end
            e = expected_q.pop_front();
            if (pb !== e.payload_byte) begin
                $error("payload_byte: expected %0h, got %0h", e.payload_byte, pb);
                fail_count++;
            end
            if (ft !== e.frame_type) begin
                $error("frame_type: expected %0h, got %0h", e.frame_type, ft);
                fail_count++;
            end
            if (hd !== e.has_data) begin
                $error("has_data: expected %0b, got %0b", e.has_data, hd);
                fail_count++;
            end
            if (ls !== e.last) begin
                $error("last: expected %0b, got %0b", e.last, ls);
                fail_count++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic steady;
    int   stall_left;
    int   idle_cycles;
    int   bytes_sent;

    frame_tracker tracker = new();

    lpd_in_if  stream_ch ();
    lpd_out_if result_ch ();

    length_prefixed_deframer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .result (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one; none in steady stretches
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one byte after a random gap and hold it until it is taken
    task automatic send_byte(input byte_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            stream_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        stream_ch.valid       <= 1'b1;
        stream_ch.stream_byte <= b;
        do
            @(posedge clk);
        while (!stream_ch.ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Send a header with the given length word and type, then the payload
    task automatic send_frame(input logic [31:0] len_word, input type_word_t ftype);
        logic [31:0] count;
        for (int i = 0; i < 4; i++)
            send_byte(len_word[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            send_byte(ftype[8*i +: 8]);
        count = len_word & LEN_MASK;
        for (int i = 0; i < int'(count); i++)
            send_byte(byte_t'($urandom_range(0, 255)));
    endtask

    // Pick a payload length, mostly small
    function automatic logic [31:0] pick_length();
        int          r;
        logic [31:0] len;
        r = $urandom_range(0, 99);
        if (r < 15)
            len = 0;
        else if (r < 80)
            len = $urandom_range(1, 8);
        else if (r < 95)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(41, 200);
        // Set ignored upper length bits now and then
        if (LENGTH_WIDTH < 32 && $urandom_range(0, 3) == 0)
            len = len | ($urandom() & ~LEN_MASK);
        return len;
    endfunction

    function automatic type_word_t pick_type();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    // Result sink: random stalls, mostly short
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end
        else if (!steady && $urandom_range(0, 99) < 20)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                            : $urandom_range(8, 40);
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    // Observe both channels and watch for a stalled run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stream_ch.valid && stream_ch.ready)
                tracker.take_byte(stream_ch.stream_byte);
            if (result_ch.valid && result_ch.ready)
                tracker.check_result(result_ch.payload_byte, result_ch.frame_type,
                                     result_ch.has_data, result_ch.last);
            if ((stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed frames, random frames, drain
    initial
    begin
        rst_n                 = 1'b0;
        steady                = 1'b0;
        stall_left            = 0;
        idle_cycles           = 0;
        bytes_sent            = 0;
        stream_ch.valid       = 1'b0;
        stream_ch.stream_byte = '0;
        result_ch.ready       = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty frame with all-ones type, one-byte frame, two-byte frame
        send_frame(32'd0, 32'hFFFF_FFFF);
        send_frame(32'd1, 32'h0000_0000);
        send_frame(32'd2, 32'h8000_0001);
        // Upper length bits beyond the kept width are dropped
        if (LENGTH_WIDTH < 32)
            send_frame(32'd3 | ~LEN_MASK, 32'h1234_5678);

        // Random frames, with a steady stretch now and then
        while (bytes_sent < BYTE_TARGET)
        begin
            steady = ($urandom_range(0, 5) == 0);
            send_frame(pick_length(), pick_type());
        end
        steady = 1'b0;
        stream_ch.valid <= 1'b0;

        // Drain outstanding results, then allow for latency
        while (tracker.expected_q.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        if (tracker.fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
